// File: hdl/pei_pkg.sv
// Package: types, constants and arithmetic helpers for the particle Euler integrator.
`timescale 1ns / 1ps

package pei_pkg;

    // Quotient bits kept for life / life_total; larger quotients are capped.
    localparam int DIV_BITS = 34;
    localparam logic [DIV_BITS-1:0] RATIO_CAP = 34'h2_0001_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    typedef enum logic [2:0]
    {
        REG_GRAV_X       = 3'd0,
        REG_GRAV_Y       = 3'd1,
        REG_GRAV_Z       = 3'd2,
        REG_DRAG         = 3'd3,
        REG_SIZE_RATE    = 3'd4,
        REG_COLOR_BEGIN  = 3'd5,
        REG_COLOR_FINISH = 3'd6
    } cfg_reg_t;

    // Word carried down the divider pipe.
    typedef struct packed
    {
        logic             pass;
        logic [15:0]      dt;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      life;
        logic [30:0]      size;
        logic [63:0]      color;
        logic [2:0][47:0] gprod;
        logic [46:0]      dprod;
        logic [47:0]      sprod;
        logic [30:0]      total;
        logic             cap;
        logic [30:0]      rem;
        logic [DIV_BITS-1:0] quo;
    } div_item_t;

    // Shift right by 16, rounding half upwards.
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] q;
        begin
            q = p + 64'sd32768;
            return q >>> 16;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        begin
            if (x < -64'sd2147483648)
                r = 32'h8000_0000;
            else if (x > 64'sd2147483647)
                r = 32'h7fff_ffff;
            else
                r = x[31:0];
            return r;
        end
    endfunction

    function automatic logic [15:0] sat16(input logic signed [63:0] x);
        logic [15:0] r;
        begin
            if (x < -64'sd32768)
                r = 16'h8000;
            else if (x > 64'sd32767)
                r = 16'h7fff;
            else
                r = x[15:0];
            return r;
        end
    endfunction

endpackage

// File: hdl/particle_euler_integrator_top.sv
// Top level: pipelined Euler update of one particle per clock.
//
//  channel | handshake        | words
//  --------+------------------+------------------------------------------------
//  input   | start / busy     | delta_time, pos/vel_*_in, life_in, life_total,
//          |                  | size_in, color_in
//  result  | done (strobe)    | pos/vel_*_out, life_out, size_out, color_out,
//          |                  | expired
//  config  | cfg_we           | cfg_index, cfg_data
//
// One word accepted per clock; busy is never raised.
// Each result passes the input register, the divider stages, P1 to P4 and the
// output register; most of the depth is the restoring divider for life / life_total, one quotient bit per stage.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The receiver takes every result in the cycle it is strobed.
`timescale 1ns / 1ps

module particle_euler_integrator_top
    import pei_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] delta_time,
    input  logic [31:0] pos_x_in,
    input  logic [31:0] pos_y_in,
    input  logic [31:0] pos_z_in,
    input  logic [31:0] vel_x_in,
    input  logic [31:0] vel_y_in,
    input  logic [31:0] vel_z_in,
    input  logic [31:0] life_in,
    input  logic [30:0] life_total,
    input  logic [30:0] size_in,
    input  logic [63:0] color_in,
    output logic        done,
    output logic [31:0] pos_x_out,
    output logic [31:0] pos_y_out,
    output logic [31:0] pos_z_out,
    output logic [31:0] vel_x_out,
    output logic [31:0] vel_y_out,
    output logic [31:0] vel_z_out,
    output logic [31:0] life_out,
    output logic [30:0] size_out,
    output logic [63:0] color_out,
    output logic        expired,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration
    logic [2:0][31:0] grav_reg;
    logic [30:0]      drag_reg;
    logic [31:0]      rate_reg;
    logic [63:0]      cbeg_reg;
    logic [63:0]      cfin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= '0;
            drag_reg <= '0;
            rate_reg <= '0;
            cbeg_reg <= '0;
            cfin_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRAV_X:       grav_reg[0] <= cfg_data[31:0];
                REG_GRAV_Y:       grav_reg[1] <= cfg_data[31:0];
                REG_GRAV_Z:       grav_reg[2] <= cfg_data[31:0];
                REG_DRAG:         drag_reg    <= cfg_data[30:0];
                REG_SIZE_RATE:    rate_reg    <= cfg_data[31:0];
                REG_COLOR_BEGIN:  cbeg_reg    <= cfg_data;
                REG_COLOR_FINISH: cfin_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input register
    logic             in_valid_reg;
    logic [15:0]      in_dt_reg;
    logic [2:0][31:0] in_pos_reg;
    logic [2:0][31:0] in_vel_reg;
    logic [31:0]      in_life_reg;
    logic [30:0]      in_total_reg;
    logic [30:0]      in_size_reg;
    logic [63:0]      in_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_dt_reg    <= delta_time;
        in_pos_reg   <= {pos_z_in, pos_y_in, pos_x_in};
        in_vel_reg   <= {vel_z_in, vel_y_in, vel_x_in};
        in_life_reg  <= life_in;
        in_total_reg <= life_total;
        in_size_reg  <= size_in;
        in_color_reg <= color_in;
    end

    // life update, products with dt, divider set-up
    div_item_t              div_reg [0:DIV_BITS];
    div_item_t              div_next [0:DIV_BITS];
    logic [DIV_BITS:0]      dv_valid_reg;
    logic signed [32:0]     life_diff;
    logic [31:0]            life_new;

    always_comb
    begin
        life_diff = $signed({in_life_reg[31], in_life_reg}) - $signed({17'd0, in_dt_reg});
        life_new  = sat32(64'(life_diff));
        div_next[0].pass  = (in_dt_reg == 16'd0);
        div_next[0].dt    = in_dt_reg;
        div_next[0].pos   = in_pos_reg;
        div_next[0].vel   = in_vel_reg;
        div_next[0].life  = life_new;
        div_next[0].size  = in_size_reg;
        div_next[0].color = in_color_reg;
        for (int i = 0; i < 3; i++)
        begin
            div_next[0].gprod[i] = 48'($signed(grav_reg[i]) * $signed({1'b0, in_dt_reg}));
        end
        div_next[0].dprod = 47'(drag_reg) * 47'(in_dt_reg);
        div_next[0].sprod = 48'($signed(rate_reg) * $signed({1'b0, in_dt_reg}));
        div_next[0].total = in_total_reg;
        div_next[0].cap   = (in_total_reg == 31'd0)
                         || ({18'd0, life_new[30:0]} >= {in_total_reg, 18'd0});
        div_next[0].rem   = {18'd0, life_new[30:18]};
        div_next[0].quo   = '0;
    end

    // restoring divider, one quotient bit a stage, MSB first
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        localparam int B = DIV_BITS - 1 - k;
        logic        dbit;
        logic [31:0] r_sh;
        logic [31:0] r_sub;
        logic        ge;

        if (B >= 16)
        begin : g_bit
            assign dbit = div_reg[k].life[B-16];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        always_comb
        begin
            r_sh          = {div_reg[k].rem, dbit};
            r_sub         = r_sh - {1'b0, div_reg[k].total};
            ge            = (r_sh >= {1'b0, div_reg[k].total});
            div_next[k+1] = div_reg[k];
            div_next[k+1].rem    = ge ? r_sub[30:0] : r_sh[30:0];
            div_next[k+1].quo[B] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else
            dv_valid_reg <= {dv_valid_reg[DIV_BITS-1:0], in_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_BITS; k++)
        begin
            div_reg[k] <= div_next[k];
        end
    end

    // P1: gravity, drag factor, size, colour weight
    logic             p1_valid_reg;
    logic             p1_pass_reg;
    logic             p1_exp_reg;
    logic [15:0]      p1_dt_reg;
    logic [2:0][31:0] p1_pos_reg;
    logic [2:0][31:0] p1_vel_reg;
    logic [16:0]      p1_f_reg;
    logic [31:0]      p1_life_reg;
    logic [30:0]      p1_size_reg;
    logic [63:0]      p1_color_reg;
    logic [35:0]      p1_t_reg;

    logic [2:0][31:0] p1_vel_next;
    logic [16:0]      p1_f_next;
    logic [30:0]      p1_size_next;
    logic [35:0]      p1_t_next;
    logic signed [63:0] drag_r;
    logic signed [63:0] size_sum;
    logic [DIV_BITS-1:0] ratio;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_vel_next[i] = sat32($signed(64'($signed(div_reg[DIV_BITS].vel[i])))
                                   + rnd16(64'($signed(div_reg[DIV_BITS].gprod[i]))));
        end
        drag_r = rnd16({17'd0, div_reg[DIV_BITS].dprod});
        if (drag_reg == 31'd0)
            p1_f_next = ONE_Q16;
        else if (drag_r >= 64'sd65536)
            p1_f_next = '0;
        else
            p1_f_next = ONE_Q16 - drag_r[16:0];
        size_sum = $signed({33'd0, div_reg[DIV_BITS].size})
                 + rnd16(64'($signed(div_reg[DIV_BITS].sprod)));
        if (size_sum < 64'sd0)
            p1_size_next = '0;
        else if (size_sum > 64'sd2147483647)
            p1_size_next = 31'h7fff_ffff;
        else
            p1_size_next = size_sum[30:0];
        if (div_reg[DIV_BITS].cap || div_reg[DIV_BITS].quo > RATIO_CAP)
            ratio = RATIO_CAP;
        else
            ratio = div_reg[DIV_BITS].quo;
        p1_t_next = 36'(ONE_Q16) - 36'(ratio);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= dv_valid_reg[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        p1_pass_reg  <= div_reg[DIV_BITS].pass;
        p1_exp_reg   <= !div_reg[DIV_BITS].pass && ($signed(div_reg[DIV_BITS].life) <= 0);
        p1_dt_reg    <= div_reg[DIV_BITS].dt;
        p1_pos_reg   <= div_reg[DIV_BITS].pos;
        p1_vel_reg   <= p1_vel_next;
        p1_f_reg     <= p1_f_next;
        p1_life_reg  <= div_reg[DIV_BITS].life;
        p1_size_reg  <= p1_size_next;
        p1_color_reg <= div_reg[DIV_BITS].color;
        p1_t_reg     <= p1_t_next;
    end

    // P2: drag and colour products
    logic             p2_valid_reg;
    logic             p2_pass_reg;
    logic             p2_exp_reg;
    logic [15:0]      p2_dt_reg;
    logic [2:0][31:0] p2_pos_reg;
    logic [2:0][49:0] p2_vprod_reg;
    logic [31:0]      p2_life_reg;
    logic [30:0]      p2_size_reg;
    logic [63:0]      p2_color_reg;
    logic [3:0][52:0] p2_cprod_reg;

    logic [3:0][52:0] p2_cprod_next;
    logic signed [16:0] cdiff;

    always_comb
    begin
        cdiff = '0;
        for (int j = 0; j < 4; j++)
        begin
            cdiff = $signed({cfin_reg[16*j+15], cfin_reg[16*j +: 16]})
                  - $signed({cbeg_reg[16*j+15], cbeg_reg[16*j +: 16]});
            p2_cprod_next[j] = 53'(cdiff * $signed(p1_t_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_pass_reg  <= p1_pass_reg;
        p2_exp_reg   <= p1_exp_reg;
        p2_dt_reg    <= p1_dt_reg;
        p2_pos_reg   <= p1_pos_reg;
        for (int i = 0; i < 3; i++)
        begin
            p2_vprod_reg[i] <= 50'($signed(p1_vel_reg[i]) * $signed({1'b0, p1_f_reg}));
        end
        p2_life_reg  <= p1_life_reg;
        p2_size_reg  <= p1_size_reg;
        p2_color_reg <= p1_color_reg;
        p2_cprod_reg <= p2_cprod_next;
    end

    // P3: round drag, finish colour
    logic             p3_valid_reg;
    logic             p3_exp_reg;
    logic [15:0]      p3_dt_reg;
    logic [2:0][31:0] p3_pos_reg;
    logic [2:0][31:0] p3_vel_reg;
    logic [31:0]      p3_life_reg;
    logic [30:0]      p3_size_reg;
    logic [63:0]      p3_color_reg;

    logic [2:0][31:0] p3_vel_next;
    logic [63:0]      p3_color_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p3_vel_next[i] = sat32(rnd16(64'($signed(p2_vprod_reg[i]))));
        end
        for (int j = 0; j < 4; j++)
        begin
            p3_color_next[16*j +: 16] =
                sat16(64'($signed(cbeg_reg[16*j +: 16]))
                      + rnd16(64'($signed(p2_cprod_reg[j]))));
        end
        if (p2_pass_reg)
            p3_color_next = p2_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p3_exp_reg   <= p2_exp_reg;
        p3_dt_reg    <= p2_dt_reg;
        p3_pos_reg   <= p2_pos_reg;
        p3_vel_reg   <= p3_vel_next;
        p3_life_reg  <= p2_life_reg;
        p3_size_reg  <= p2_size_reg;
        p3_color_reg <= p3_color_next;
    end

    // P4: position step product
    logic             p4_valid_reg;
    logic             p4_exp_reg;
    logic [2:0][31:0] p4_pos_reg;
    logic [2:0][31:0] p4_vel_reg;
    logic [2:0][47:0] p4_pprod_reg;
    logic [31:0]      p4_life_reg;
    logic [30:0]      p4_size_reg;
    logic [63:0]      p4_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else
            p4_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p4_exp_reg   <= p3_exp_reg;
        p4_pos_reg   <= p3_pos_reg;
        p4_vel_reg   <= p3_vel_reg;
        for (int i = 0; i < 3; i++)
        begin
            p4_pprod_reg[i] <= 48'($signed(p3_vel_reg[i]) * $signed({1'b0, p3_dt_reg}));
        end
        p4_life_reg  <= p3_life_reg;
        p4_size_reg  <= p3_size_reg;
        p4_color_reg <= p3_color_reg;
    end

    // output register; an expired particle leaves only life
    logic             out_valid_reg;
    logic             out_exp_reg;
    logic [2:0][31:0] out_pos_reg;
    logic [2:0][31:0] out_vel_reg;
    logic [31:0]      out_life_reg;
    logic [30:0]      out_size_reg;
    logic [63:0]      out_color_reg;
    logic [2:0][31:0] out_pos_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_pos_next[i] = sat32(64'($signed(p4_pos_reg[i]))
                                    + rnd16(64'($signed(p4_pprod_reg[i]))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_exp_reg   <= p4_exp_reg;
        out_pos_reg   <= p4_exp_reg ? '0 : out_pos_next;
        out_vel_reg   <= p4_exp_reg ? '0 : p4_vel_reg;
        out_life_reg  <= p4_life_reg;
        out_size_reg  <= p4_exp_reg ? '0 : p4_size_reg;
        out_color_reg <= p4_exp_reg ? '0 : p4_color_reg;
    end

    assign done      = out_valid_reg;
    assign expired   = out_exp_reg;
    assign pos_x_out = out_pos_reg[0];
    assign pos_y_out = out_pos_reg[1];
    assign pos_z_out = out_pos_reg[2];
    assign vel_x_out = out_vel_reg[0];
    assign vel_y_out = out_vel_reg[1];
    assign vel_z_out = out_vel_reg[2];
    assign life_out  = out_life_reg;
    assign size_out  = out_size_reg;
    assign color_out = out_color_reg;

    a_exp_life: assert property (@(posedge clk) disable iff (!rst_n)
        done && expired |-> (life_out[31] || life_out == 32'd0))
        else $error("expired word with positive life");

    a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && expired |-> (pos_x_out == 32'd0 && vel_x_out == 32'd0
                             && size_out == 31'd0 && color_out == 64'd0))
        else $error("expired word carries stale fields");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_BITS] && !div_reg[DIV_BITS].cap
         && $signed(div_reg[DIV_BITS].life) > 0)
        |-> (div_reg[DIV_BITS].rem < div_reg[DIV_BITS].total))
        else $error("divider remainder out of range");

    a_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
        p4_valid_reg |=> done)
        else $error("result strobe lost");

endmodule
